[rtl/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared codes and default sizes for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int CAPACITY_DEFAULT   = 32;
  localparam int KEY_BITS_DEFAULT   = 32;
  localparam int VALUE_BITS_DEFAULT = 32;

  // request codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // result codes
  localparam logic [1:0] RES_DONE    = 2'd0;
  localparam logic [1:0] RES_PRESENT = 2'd1;
  localparam logic [1:0] RES_MISSING = 2'd2;
  localparam logic [1:0] RES_FULL    = 2'd3;

  // slot states
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

endpackage

[rtl/lpht_home.sv]
// ----------------------------------------------------------------------------
// lpht_home
// Home slot of a key: key modulo the table capacity. A power-of-two capacity, or a key
// narrower than the address, takes the low bits; otherwise the quotient comes from a
// multiply by the rounded-up reciprocal and the remainder is formed in the low address bits.
// ----------------------------------------------------------------------------
module lpht_home #(
  parameter int CAPACITY = 32,
  parameter int KEY_W    = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [KEY_W-1:0]            key,
  output logic                        done,
  output logic [$clog2(CAPACITY)-1:0] home
);

  localparam int AW = $clog2(CAPACITY);

  generate
    // a key narrower than the address is always below the capacity
    if (((CAPACITY & (CAPACITY - 1)) == 0) || (KEY_W < AW)) begin : g_mask
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          home <= AW'(key);
        end
      end
    end else begin : g_recip
      localparam int SH = KEY_W + AW;
      localparam int QW = KEY_W + 1 - AW;
      // ceil(2^SH / CAPACITY) gives the exact quotient for every key
      localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
      localparam logic [KEY_W:0] RECIP = RECIP_FULL[KEY_W:0];

      logic [2*KEY_W:0] prod;
      logic [QW-1:0]    quot;
      logic [AW-1:0]    key_lo;
      logic [AW-1:0]    qc_lo;

      assign prod = {{(KEY_W + 1){1'b0}}, key} * {{KEY_W{1'b0}}, RECIP};

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          quot   <= prod[2*KEY_W:SH];
          key_lo <= AW'(key);
        end
      end

      // remainder fits in the address bits, so only the low bits are needed
      assign qc_lo = AW'(quot) * AW'(CAPACITY);
      assign home  = key_lo - qc_lo;
    end
  endgenerate

endmodule

[rtl/linear_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing; insert, delete, lookup.
// ----------------------------------------------------------------------------
// probe: the result beat follows once a slot ends the probe (a hit, an empty slot or
//   the last of up to CAPACITY slots probed)
// throughput: one request at a time, next beat taken the cycle after the result
//   is loaded; the slot memory read port probes one slot per cycle
// reset: after rst the slot memory is swept to empty, with s_axis_tready low
module linear_probe_hash_table #(
  parameter int CAPACITY   = lpht_pkg::CAPACITY_DEFAULT,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEFAULT,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value_out[31:0], entry_count[37:32],
                                      // table_empty[38], zero[39]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int KW   = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW   = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int MW   = 2 + KW + VW;
  localparam int CNTW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_HOME   = 3'd2;
  localparam logic [2:0] ST_PROBE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]      state;
  logic [AW-1:0]   clr_addr;
  logic [1:0]      action_r;
  logic [KW-1:0]   key_r;
  logic [VW-1:0]   value_r;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_next;

  logic [AW-1:0]   probe_addr;
  logic [CNTW-1:0] n_issued;
  logic            chk_valid;
  logic [AW-1:0]   chk_addr;
  logic            chk_last;
  logic            found;
  logic [AW-1:0]   found_addr;
  logic [VW-1:0]   found_value;
  logic            free_valid;
  logic [AW-1:0]   free_addr;

  logic [MW-1:0]   mem [CAPACITY];
  logic [MW-1:0]   rd_data;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [MW-1:0]   mem_wdata;

  logic            in_beat;
  logic            home_start;
  logic            home_done;
  logic [AW-1:0]   home;
  logic [KW-1:0]   key_in;

  logic [1:0]      rd_status;
  logic [KW-1:0]   rd_key;
  logic [VW-1:0]   rd_value;
  logic            hit_now;
  logic            empty_now;
  logic            tomb_now;
  logic            stop;
  logic [AW-1:0]   probe_addr_next;

  logic            out_free;
  logic [1:0]      res_status;
  logic [VW-1:0]   res_value;

  logic [31:0]     m_value;
  logic [1:0]      m_status;
  logic [5:0]      m_count;
  logic            m_empty;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign key_in        = s_axis_tdata[KW-1:0];
  assign home_start    = in_beat && (s_axis_tuser != lpht_pkg::ACT_UNUSED);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  lpht_home #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KW)
  ) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (home_start),
    .key   (key_in),
    .done  (home_done),
    .home  (home)
  );

  // slot memory: {status, key, value}
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[probe_addr];
  end

  assign rd_status = rd_data[MW-1 -: 2];
  assign rd_key    = rd_data[VW +: KW];
  assign rd_value  = rd_data[VW-1:0];

  assign hit_now   = chk_valid && rd_status == lpht_pkg::SLOT_LIVE && rd_key == key_r;
  assign empty_now = chk_valid && rd_status == lpht_pkg::SLOT_EMPTY;
  assign tomb_now  = chk_valid && rd_status == lpht_pkg::SLOT_TOMB;
  assign stop      = hit_now || empty_now || (chk_valid && chk_last);

  assign probe_addr_next = (probe_addr == AW'(CAPACITY - 1)) ? '0 : probe_addr + AW'(1);

  // write port and result selection
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = clr_addr;
    mem_wdata  = {lpht_pkg::SLOT_EMPTY, {(KW + VW){1'b0}}};
    count_next = count;
    res_status = lpht_pkg::RES_MISSING;
    res_value  = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_FINISH) begin
      unique case (action_r)
        lpht_pkg::ACT_INSERT: begin
          if (found) begin
            res_status = lpht_pkg::RES_PRESENT;
          end else if (!free_valid) begin
            res_status = lpht_pkg::RES_FULL;
          end else begin
            mem_we     = out_free;
            mem_waddr  = free_addr;
            mem_wdata  = {lpht_pkg::SLOT_LIVE, key_r, value_r};
            count_next = count + CNTW'(1);
            res_status = lpht_pkg::RES_DONE;
          end
        end
        lpht_pkg::ACT_DELETE: begin
          if (found) begin
            mem_we     = out_free;
            mem_waddr  = found_addr;
            mem_wdata  = {lpht_pkg::SLOT_TOMB, key_r, found_value};
            count_next = (count != '0) ? count - CNTW'(1) : count;
            res_status = lpht_pkg::RES_DONE;
            res_value  = found_value;
          end
        end
        lpht_pkg::ACT_LOOKUP: begin
          if (found) begin
            res_status = lpht_pkg::RES_DONE;
            res_value  = found_value;
          end
        end
        default: begin
          res_status = lpht_pkg::RES_MISSING;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      count         <= '0;
      chk_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CAPACITY - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_beat) begin
            state <= home_start ? ST_HOME : ST_FINISH;
          end
        end
        ST_HOME: begin
          if (home_done) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (stop) begin
            state     <= ST_FINISH;
            chk_valid <= 1'b0;
          end else begin
            chk_valid <= (n_issued != CNTW'(CAPACITY));
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            count <= count_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request and probe payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      action_r <= s_axis_tuser;
      key_r    <= key_in;
      value_r  <= s_axis_tdata[32 +: VW];
      found    <= 1'b0;
    end
    if (state == ST_HOME && home_done) begin
      probe_addr <= home;
      n_issued   <= '0;
      free_valid <= 1'b0;
    end
    if (state == ST_PROBE) begin
      // first tombstone wins over the empty slot that ends the chain
      if ((tomb_now || empty_now) && !free_valid) begin
        free_valid <= 1'b1;
        free_addr  <= chk_addr;
      end
      if (hit_now) begin
        found       <= 1'b1;
        found_addr  <= chk_addr;
        found_value <= rd_value;
      end
      if (!stop && n_issued != CNTW'(CAPACITY)) begin
        chk_addr   <= probe_addr;
        chk_last   <= (n_issued == CNTW'(CAPACITY - 1));
        probe_addr <= probe_addr_next;
        n_issued   <= n_issued + CNTW'(1);
      end
    end
    if (state == ST_FINISH && out_free) begin
      m_value  <= 32'(res_value);
      m_status <= res_status;
      m_count  <= 6'(count_next);
      m_empty  <= (count_next == '0);
    end
  end

  assign m_axis_tdata = {1'b0, m_empty, m_count, m_value};
  assign m_axis_tuser = m_status;

endmodule
